// ----- sv/icv_pkg.sv -----
// icv_pkg: shared widths, register indices, types and helpers for the 3x3 convolution block
// no dependencies; used by every other file of the block
`default_nettype none

package icv_pkg;

  localparam int KSIZE        = 3;
  localparam int KTAPS        = KSIZE * KSIZE;
  localparam int CENTRE_TAP   = KTAPS / 2;
  localparam int PIX_W        = 8;
  localparam int COEF_W       = 16;
  localparam int KROW_W       = KSIZE * COEF_W;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 13;
  localparam int CALC_W       = 13;
  localparam int MIN_DIM      = 3;
  localparam int MAX_HEIGHT   = 4096;
  localparam int FRAC_BITS    = 12;
  localparam int PROD_W       = PIX_W + 1 + COEF_W;
  localparam int RSUM_W       = PROD_W + 2;
  localparam int SUM_W        = RSUM_W + 2;
  localparam int PIX_MAX      = 255;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = KROW_W;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_TOP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_MID = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROW_BOT = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KTAPS-1:0][PIX_W-1:0] window_t;
  typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } meta_t;

  // coefficient c of a packed kernel row, left column in the low bits
  function automatic logic signed [COEF_W-1:0] coef(input logic [KROW_W-1:0] krow,
                                                    input int unsigned c);
    return signed'(krow[c*COEF_W +: COEF_W]);
  endfunction

endpackage

`default_nettype wire

// ----- sv/icv_pixel_in_if.sv -----
// icv_pixel_in_if: input pixel channel, valid/ready with pixel and flush flag
// depends on icv_pkg
`default_nettype none

interface icv_pixel_in_if;
  logic                    valid;
  logic                    ready;
  logic [icv_pkg::PIX_W-1:0] pixel_in;
  logic                    is_flush;

  modport source (output valid, pixel_in, is_flush, input ready);
  modport sink   (input valid, pixel_in, is_flush, output ready);
endinterface

`default_nettype wire

// ----- sv/icv_pixel_out_if.sv -----
// icv_pixel_out_if: output pixel channel, valid/ready with pixel and end-of-frame flag
// depends on icv_pkg
`default_nettype none

interface icv_pixel_out_if;
  logic                    valid;
  logic                    ready;
  logic [icv_pkg::PIX_W-1:0] pixel_out;
  logic                    frame_end;

  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink   (input valid, pixel_out, frame_end, output ready);
endinterface

`default_nettype wire

// ----- sv/icv_ctrl.sv -----
// icv_ctrl: input position counters, geometry clamping and per-pixel border/emit flags
// depends on icv_pkg
`default_nettype none

module icv_ctrl #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [icv_pkg::WIDTH_REG_W-1:0]   image_width,
  input  logic [icv_pkg::HEIGHT_REG_W-1:0]  image_height,
  output logic [COL_W-1:0]                  addr,
  output icv_pkg::meta_t                    meta
);

  localparam int CW = icv_pkg::CALC_W;

  logic [COL_W-1:0]            in_column, in_column_next;
  logic [icv_pkg::ROW_W-1:0]   in_row, in_row_next;
  logic [CW-1:0]               w_eff, h_eff, w_raw, h_raw, col_ext, ocol;
  logic [icv_pkg::ROW_W-1:0]   orow;

  assign w_raw   = CW'(image_width);
  assign h_raw   = CW'(image_height);
  assign col_ext = CW'(in_column);

  always_comb begin
    if (w_raw < CW'(icv_pkg::MIN_DIM)) begin
      w_eff = CW'(icv_pkg::MIN_DIM);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < CW'(icv_pkg::MIN_DIM)) begin
      h_eff = CW'(icv_pkg::MIN_DIM);
    end else if (h_raw > CW'(icv_pkg::MAX_HEIGHT)) begin
      h_eff = CW'(icv_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // the result leaving now belongs to the pixel one row plus one pixel back
  always_comb begin
    meta.emit = (in_row >= icv_pkg::ROW_W'(2)) ||
                (in_row == icv_pkg::ROW_W'(1) && in_column != '0);
    if (in_column != '0) begin
      orow = in_row - icv_pkg::ROW_W'(1);
      ocol = col_ext - CW'(1);
    end else begin
      orow = in_row - icv_pkg::ROW_W'(2);
      ocol = w_eff - CW'(1);
    end
    meta.border = (orow == '0) || (CW'(orow) >= h_eff - CW'(1)) ||
                  (ocol == '0) || (ocol >= w_eff - CW'(1));
    meta.last   = (CW'(orow) >= h_eff - CW'(1)) && (ocol >= w_eff - CW'(1));
  end

  assign addr = in_column;

  always_comb begin
    if (col_ext + CW'(1) >= w_eff) begin
      in_column_next = '0;
      in_row_next    = in_row + icv_pkg::ROW_W'(1);
    end else begin
      in_column_next = in_column + COL_W'(1);
      in_row_next    = in_row;
    end
    // end of frame: start the next one from the top left
    if (meta.emit && meta.last) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (advance) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    advance && meta.emit && meta.last |=> in_column == '0 && in_row == '0)
    else $error("counters not cleared after last pixel");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    meta.emit && meta.last |-> meta.border)
    else $error("last pixel not treated as border");

endmodule

`default_nettype wire

// ----- sv/icv_line_buffer.sv -----
// icv_line_buffer: two row memories with forwarding and the 3x3 pixel window
// depends on icv_pkg
`default_nettype none

module icv_line_buffer #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [AW-1:0]       addr,
  input  icv_pkg::pix_t       pix,
  input  logic                commit,
  output icv_pkg::window_t    win
);

  localparam int K = icv_pkg::KSIZE;

  icv_pkg::pix_t mem_a [MAX_WIDTH];
  icv_pkg::pix_t mem_b [MAX_WIDTH];

  logic [AW-1:0]  addr_s1;
  icv_pkg::pix_t  pix_s1, rd_a, rd_b, fwd_a, fwd_b, above1, above2;
  logic           hit;

  // a read that meets the write of the item ahead takes the written data
  assign above1 = hit ? fwd_a : rd_a;
  assign above2 = hit ? fwd_b : rd_b;

  always_ff @(posedge clk) begin
    if (commit) begin
      mem_a[addr_s1] <= pix_s1;
    end
    if (load) begin
      rd_a <= mem_a[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      mem_b[addr_s1] <= above1;
    end
    if (load) begin
      rd_b <= mem_b[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_s1 <= addr;
      pix_s1  <= pix;
      hit     <= commit && (addr_s1 == addr);
      fwd_a   <= pix_s1;
      fwd_b   <= above1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (commit) begin
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K - 1; c++) begin
          win[r*K + c] <= win[r*K + c + 1];
        end
      end
      win[K-1]     <= above2;
      win[2*K-1]   <= above1;
      win[K*K-1]   <= pix_s1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/icv_mac.sv -----
// icv_mac: nine coefficient products, row sums, final sum with truncation and saturation
// depends on icv_pkg
`default_nettype none

module icv_mac (
  input  logic              clk,
  input  logic              en_prod,
  input  logic              en_rsum,
  input  icv_pkg::window_t  win,
  input  icv_pkg::kernel_t  krow,
  input  icv_pkg::meta_t    meta_in,
  output icv_pkg::meta_t    meta_out,
  output icv_pkg::pix_t     result
);

  localparam int K  = icv_pkg::KSIZE;
  localparam int SW = icv_pkg::SUM_W;

  logic signed [icv_pkg::PROD_W-1:0] prod [icv_pkg::KTAPS];
  logic signed [icv_pkg::RSUM_W-1:0] rsum [K];
  logic signed [SW-1:0]              sum;
  logic [SW-icv_pkg::FRAC_BITS-1:0]  shifted;
  icv_pkg::pix_t                     centre_p, centre_r, sat;
  icv_pkg::meta_t                    meta_p;

  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K; c++) begin
          prod[r*K + c] <= $signed({1'b0, win[r*K + c]}) * icv_pkg::coef(krow[r], c);
        end
      end
      centre_p <= win[icv_pkg::CENTRE_TAP];
      meta_p   <= meta_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en_rsum) begin
      for (int r = 0; r < K; r++) begin
        rsum[r] <= icv_pkg::RSUM_W'(prod[r*K]) + icv_pkg::RSUM_W'(prod[r*K + 1]) +
                   icv_pkg::RSUM_W'(prod[r*K + 2]);
      end
      centre_r <= centre_p;
      meta_out <= meta_p;
    end
  end

  assign sum     = SW'(rsum[0]) + SW'(rsum[1]) + SW'(rsum[2]);
  assign shifted = sum[SW-1:icv_pkg::FRAC_BITS];

  // non-positive sums clamp to black, large ones to white
  always_comb begin
    if (sum <= 0) begin
      sat = '0;
    end else if (shifted > (SW-icv_pkg::FRAC_BITS)'(icv_pkg::PIX_MAX)) begin
      sat = icv_pkg::PIX_W'(icv_pkg::PIX_MAX);
    end else begin
      sat = shifted[icv_pkg::PIX_W-1:0];
    end
  end

  assign result = meta_out.border ? centre_r : sat;

endmodule

`default_nettype wire

// ----- sv/image_convolution_3x3.sv -----
// image_convolution_3x3: 3x3 convolution on a raster stream of 8-bit grayscale pixels with
// Q4.12 coefficients; border pixels pass through unchanged and the sum is truncated toward zero
// and clamped to 0..255. One input transfer is taken per clock, pixel or flush, so the block
// sustains one item per cycle unless the output stalls; each row memory has one write and one
// read port, which sets that figure. A result leaves one row plus one pixel of input and the
// pipeline after its pixel; flush transfers push out the tail of a frame. Line memories need
// no clearing after reset. Configuration writes belong between frames, with the pipeline empty.
// depends on icv_pkg, icv_pixel_in_if, icv_pixel_out_if, icv_ctrl, icv_line_buffer, icv_mac
`default_nettype none

module image_convolution_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [icv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0]      cfg_data,
  icv_pixel_in_if.sink                        pix_in,
  icv_pixel_out_if.source                     pix_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [icv_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [icv_pkg::HEIGHT_REG_W-1:0] image_height;
  icv_pkg::kernel_t                 krow;

  logic              acc, commit, en_prod, en_rsum, out_load;
  logic              s1_v, s2_v, s3_v, s4_v, out_v;
  logic              s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
  logic [COL_W-1:0]  addr;
  icv_pkg::pix_t     pix, result;
  icv_pkg::meta_t    meta0, meta1, meta2, meta4;
  icv_pkg::window_t  win;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= icv_pkg::WIDTH_REG_W'(1024);
      image_height <= icv_pkg::HEIGHT_REG_W'(1024);
      krow[0]      <= '0;
      krow[1]      <= icv_pkg::KROW_W'(4096);
      krow[2]      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icv_pkg::REG_IMAGE_WIDTH:    image_width  <= cfg_data[icv_pkg::WIDTH_REG_W-1:0];
        icv_pkg::REG_IMAGE_HEIGHT:   image_height <= cfg_data[icv_pkg::HEIGHT_REG_W-1:0];
        icv_pkg::REG_KERNEL_ROW_TOP: krow[0]      <= cfg_data;
        icv_pkg::REG_KERNEL_ROW_MID: krow[1]      <= cfg_data;
        icv_pkg::REG_KERNEL_ROW_BOT: krow[2]      <= cfg_data;
        default: ;
      endcase
    end
  end

  // each stage moves when empty or when the one after it moves;
  // items with no result vanish after the window update
  assign out_rdy = !out_v || pix_out.ready;
  assign s4_rdy  = !s4_v || out_rdy;
  assign s3_rdy  = !s3_v || s4_rdy;
  assign s2_rdy  = !s2_v || !meta2.emit || s3_rdy;
  assign s1_rdy  = !s1_v || s2_rdy;

  assign pix_in.ready = s1_rdy;
  assign acc      = pix_in.valid && s1_rdy;
  assign commit   = s1_v && s2_rdy;
  assign en_prod  = s2_v && meta2.emit && s3_rdy;
  assign en_rsum  = s3_v && s4_rdy;
  assign out_load = s4_v && out_rdy;

  // a flush feeds a black pixel
  assign pix = pix_in.is_flush ? '0 : pix_in.pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= pix_in.valid;
      if (s2_rdy) s2_v <= s1_v;
      if (s3_rdy) s3_v <= s2_v && meta2.emit;
      if (s4_rdy) s4_v <= s3_v;
      if (out_rdy) out_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      meta1 <= meta0;
    end
    if (commit) begin
      meta2 <= meta1;
    end
    if (out_load) begin
      pix_out.pixel_out <= result;
      pix_out.frame_end <= meta4.last;
    end
  end

  assign pix_out.valid = out_v;

  icv_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (acc),
    .image_width  (image_width),
    .image_height (image_height),
    .addr         (addr),
    .meta         (meta0)
  );

  icv_line_buffer #(.MAX_WIDTH(MAX_WIDTH)) u_line_buffer (
    .clk    (clk),
    .rst    (rst),
    .load   (acc),
    .addr   (addr),
    .pix    (pix),
    .commit (commit),
    .win    (win)
  );

  icv_mac u_mac (
    .clk      (clk),
    .en_prod  (en_prod),
    .en_rsum  (en_rsum),
    .win      (win),
    .krow     (krow),
    .meta_in  (meta2),
    .meta_out (meta4),
    .result   (result)
  );

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> pix_out.valid && !pix_out.ready)
    else $error("input stalled while output side free");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_out.valid) |-> $past(s4_v))
    else $error("result appeared without a pipeline item");

endmodule

`default_nettype wire

// ----- tb/image_convolution_3x3_test.sv -----
// image_convolution_3x3_test: self-checking bench for the 3x3 convolution block, one frame at a time
// holds its own filter predictor in a scoreboard class; needs icv_pkg, both channel interfaces
// and image_convolution_3x3
module image_convolution_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 1024;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 60;
  localparam int MAX_REPORTS    = 200;

  localparam logic [icv_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED =
      icv_pkg::REG_KERNEL_ROW_BOT + 1'b1;

  localparam logic [icv_pkg::COEF_W-1:0] COEF_MAX  = 16'h7fff;
  localparam logic [icv_pkg::COEF_W-1:0] COEF_MIN  = 16'h8000;
  localparam logic [icv_pkg::COEF_W-1:0] COEF_ONE  = 16'h1000;
  localparam logic [icv_pkg::COEF_W-1:0] COEF_ZERO = 16'h0000;

  typedef enum int {COEF_RANDOM, COEF_SMALL, COEF_EXTREME} coef_style_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [icv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [icv_pkg::CFG_DATA_W-1:0] cfg_data;

  icv_pixel_in_if pix_in ();
  icv_pixel_out_if pix_out ();

  image_convolution_3x3 #(
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  class conv_checker;
    typedef struct {
      logic [icv_pkg::PIX_W-1:0] pixel;
      logic                      frame_end;
    } filtered_t;

    logic [icv_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [icv_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [icv_pkg::KROW_W-1:0]       krow [icv_pkg::KSIZE];
    bit [icv_pkg::PIX_W-1:0] line_a [MAX_W];
    bit [icv_pkg::PIX_W-1:0] line_b [MAX_W];
    bit [icv_pkg::PIX_W-1:0] win [icv_pkg::KTAPS];
    int unsigned in_col;
    int unsigned in_row;
    filtered_t filtered_q [$];
    int errors;
    int results_seen;

    function new();
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      krow[0]    = '0;
      krow[1]    = 48'd4096;
      krow[2]    = '0;
    endfunction

    function void write_reg(logic [icv_pkg::CFG_INDEX_W-1:0] index,
                            logic [icv_pkg::CFG_DATA_W-1:0] data);
      case (index)
        icv_pkg::REG_IMAGE_WIDTH:    width_reg = data[icv_pkg::WIDTH_REG_W-1:0];
        icv_pkg::REG_IMAGE_HEIGHT:   height_reg = data[icv_pkg::HEIGHT_REG_W-1:0];
        icv_pkg::REG_KERNEL_ROW_TOP: krow[0] = data[icv_pkg::KROW_W-1:0];
        icv_pkg::REG_KERNEL_ROW_MID: krow[1] = data[icv_pkg::KROW_W-1:0];
        icv_pkg::REG_KERNEL_ROW_BOT: krow[2] = data[icv_pkg::KROW_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg < icv_pkg::MIN_DIM) return icv_pkg::MIN_DIM;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < icv_pkg::MIN_DIM) return icv_pkg::MIN_DIM;
      if (height_reg > icv_pkg::MAX_HEIGHT) return icv_pkg::MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return in_col == 0 && in_row == 0;
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    // weighted sum of the window, truncated toward zero and clamped to a pixel
    function logic [icv_pkg::PIX_W-1:0] weighted_sum();
      int acc;
      int k;
      acc = 0;
      for (int r = 0; r < icv_pkg::KSIZE; r++) begin
        for (int c = 0; c < icv_pkg::KSIZE; c++) begin
          k = $signed(krow[r][c*icv_pkg::COEF_W +: icv_pkg::COEF_W]);
          acc += int'(win[r*icv_pkg::KSIZE + c]) * k;
        end
      end
      if (acc <= 0) return '0;
      acc = acc >>> icv_pkg::FRAC_BITS;
      return (acc > icv_pkg::PIX_MAX) ? icv_pkg::PIX_W'(icv_pkg::PIX_MAX) :
                                        acc[icv_pkg::PIX_W-1:0];
    endfunction

    function void accept_pixel(logic [icv_pkg::PIX_W-1:0] px, logic flush);
      int unsigned w, h, idx, orow, ocol;
      bit [icv_pkg::PIX_W-1:0] pix, above2, above1;
      bit emit, border, last;
      filtered_t res;
      w = eff_w();
      h = eff_h();
      pix = flush ? '0 : px;
      idx = (in_col < MAX_W) ? in_col : 0;
      above2 = line_b[idx];
      above1 = line_a[idx];
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      line_b[idx] = above1;
      line_a[idx] = pix;
      for (int r = 0; r < icv_pkg::KSIZE; r++) begin
        win[r*icv_pkg::KSIZE]     = win[r*icv_pkg::KSIZE + 1];
        win[r*icv_pkg::KSIZE + 1] = win[r*icv_pkg::KSIZE + 2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = pix;
      orow = 0;
      ocol = 0;
      if (emit) begin
        if (in_col >= 1) begin
          orow = in_row - 1;
          ocol = in_col - 1;
        end else begin
          orow = in_row - 2;
          ocol = w - 1;
        end
      end
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row = (in_row + 1) & 32'h1fff;
      end else begin
        in_col++;
      end
      if (emit) begin
        border = orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1;
        last = orow >= h - 1 && ocol >= w - 1;
        res.pixel = border ? win[icv_pkg::CENTRE_TAP] : weighted_sum();
        res.frame_end = last;
        filtered_q.push_back(res);
        if (last) begin
          in_col = 0;
          in_row = 0;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("error: %s", msg);
    endtask

    task check_pixel(logic [icv_pkg::PIX_W-1:0] px, logic fe);
      filtered_t want;
      results_seen++;
      if (filtered_q.size() == 0) begin
        report($sformatf("result %0d: pixel %0d frame_end %0b with nothing expected",
                         results_seen, px, fe));
        return;
      end
      want = filtered_q.pop_front();
      if (px !== want.pixel)
        report($sformatf("result %0d: pixel_out %0d, expected %0d", results_seen, px,
                         want.pixel));
      if (fe !== want.frame_end)
        report($sformatf("result %0d: frame_end %0b, expected %0b", results_seen, fe,
                         want.frame_end));
    endtask
  endclass

  conv_checker sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  logic recv_hold;
  int idle_cycles;
  int items_sent;

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pix_out.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready) sb.accept_pixel(pix_in.pixel_in, pix_in.is_flush);
      if (pix_out.valid && pix_out.ready) sb.check_pixel(pix_out.pixel_out, pix_out.frame_end);
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // valid stays high from one item to the next unless an idle cycle comes in between
  task automatic send_item(input logic [icv_pkg::PIX_W-1:0] px, input logic flush);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.pixel_in <= px;
    pix_in.is_flush <= flush;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [icv_pkg::CFG_INDEX_W-1:0] index,
                           input logic [icv_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [icv_pkg::CFG_DATA_W-1:0] w,
                           input logic [icv_pkg::CFG_DATA_W-1:0] h,
                           input logic [icv_pkg::KROW_W-1:0] k_top,
                           input logic [icv_pkg::KROW_W-1:0] k_mid,
                           input logic [icv_pkg::KROW_W-1:0] k_bot);
    wait_idle();
    write_reg(icv_pkg::REG_IMAGE_WIDTH, w);
    write_reg(icv_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(icv_pkg::REG_KERNEL_ROW_TOP, k_top);
    write_reg(icv_pkg::REG_KERNEL_ROW_MID, k_mid);
    write_reg(icv_pkg::REG_KERNEL_ROW_BOT, k_bot);
  endtask

  function automatic logic [icv_pkg::COEF_W-1:0] pick_coef(input coef_style_t style);
    case (style)
      COEF_SMALL: return icv_pkg::COEF_W'($urandom_range(2048)) - icv_pkg::COEF_W'(1024);
      COEF_EXTREME: begin
        case ($urandom_range(3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_ONE;
          default: return COEF_ZERO;
        endcase
      end
      default: return icv_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [icv_pkg::KROW_W-1:0] pick_row(input coef_style_t style);
    return {pick_coef(style), pick_coef(style), pick_coef(style)};
  endfunction

  task automatic configure_random();
    logic [icv_pkg::CFG_DATA_W-1:0] w, h;
    coef_style_t style;
    w = ($urandom_range(99) < 15) ? icv_pkg::CFG_DATA_W'($urandom_range(2)) :
                                    icv_pkg::CFG_DATA_W'($urandom_range(3, 24));
    h = ($urandom_range(99) < 15) ? icv_pkg::CFG_DATA_W'($urandom_range(2)) :
                                    icv_pkg::CFG_DATA_W'($urandom_range(3, 8));
    // junk above the register width must be dropped
    if ($urandom_range(3) == 0) begin
      w[icv_pkg::CFG_DATA_W-1:icv_pkg::WIDTH_REG_W] =
          (icv_pkg::CFG_DATA_W-icv_pkg::WIDTH_REG_W)'({$urandom, $urandom});
      h[icv_pkg::CFG_DATA_W-1:icv_pkg::HEIGHT_REG_W] =
          (icv_pkg::CFG_DATA_W-icv_pkg::HEIGHT_REG_W)'({$urandom, $urandom});
    end
    style = coef_style_t'($urandom_range(2));
    configure(w, h, pick_row(style), pick_row(style), pick_row(style));
  endtask

  task automatic send_some(input int count, input int flush_pct);
    repeat (count) send_item(icv_pkg::PIX_W'($urandom), $urandom_range(99) < flush_pct);
  endtask

  // feeds items until the frame wraps; the tail after the last pixel is mostly flushes
  task automatic run_frame(input int flush_pct, input bit extremes);
    int n;
    int area;
    logic [icv_pkg::PIX_W-1:0] px;
    n = 0;
    area = int'(sb.eff_h() * sb.eff_w());
    do begin
      px = extremes ? ($urandom_range(1) ? 8'hff : 8'h00) : icv_pkg::PIX_W'($urandom);
      if (n < area) send_item(px, $urandom_range(99) < flush_pct);
      else send_item(px, $urandom_range(99) < 80);
      n++;
    end while (!sb.at_frame_start());
  endtask

  initial begin
    int start;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.pixel_in = '0;
    pix_in.is_flush = 1'b0;
    pix_out.ready = 1'b0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    items_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // smallest image via clamping, kernel driving the sum into saturation
    configure(48'd1, 48'd2, {3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
    run_frame(0, 1);
    // most negative kernel, interior clamps to zero; flushes inside the frame
    configure(48'd4, 48'd3, {3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
    run_frame(20, 1);
    // writes beyond the register list change nothing
    wait_idle();
    for (int i = REG_FIRST_UNUSED; i < 2**icv_pkg::CFG_INDEX_W; i++)
      write_reg(icv_pkg::CFG_INDEX_W'(i), icv_pkg::CFG_DATA_W'({$urandom, $urandom}));
    run_frame(0, 0);
    // geometry shrunk part-way through a frame, column already past the new width
    configure(48'd8, 48'd6, pick_row(COEF_SMALL), {COEF_ZERO, COEF_ONE, COEF_ZERO},
              pick_row(COEF_SMALL));
    run_frame(5, 0);
    send_some(8 * 3 + 7, 5);
    wait_idle();
    write_reg(icv_pkg::REG_IMAGE_WIDTH, 48'd5);
    write_reg(icv_pkg::REG_IMAGE_HEIGHT, 48'd4);
    run_frame(5, 0);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      start = items_sent;
      if (mode == 0) begin
        // long output hold-off while input keeps coming, so the block backs up
        configure(48'd6, 48'd12, pick_row(COEF_SMALL), pick_row(COEF_SMALL),
                  pick_row(COEF_SMALL));
        fork
          begin
            recv_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            recv_hold <= 1'b0;
          end
        join_none
        run_frame(3, 0);
      end
      while (items_sent - start < PHASE_ITEMS) begin
        configure_random();
        repeat ($urandom_range(1, 3)) run_frame($urandom_range(10), $urandom_range(9) == 0);
      end
    end

    // widest image through clamping: the first row and the start of the next
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure({37'($urandom), 11'h7ff}, 48'd3, pick_row(COEF_SMALL), pick_row(COEF_SMALL),
              pick_row(COEF_SMALL));
    send_some(MAX_W + 8, 5);

    wait_idle();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
